// File: design/ajr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ajr_pkg
// Shared types and constants of the audio jitter reservoir.
// ---------------------------------------------------------------------------
package ajr_pkg;

    localparam int CAPACITY_DEF     = 1024;
    localparam int FADE_LEN_DEF     = 16;
    localparam int MAX_PULL         = 64;

    localparam logic [10:0] WATERMARK_RST = 11'd256;
    localparam logic [6:0]  PULL_RST      = 7'd64;
    localparam logic [1:0]  CHANNELS_RST  = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_PULL   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_WATERMARK = 2'd0,
        REG_PULL      = 2'd1,
        REG_CHANNELS  = 2'd2
    } t_reg;

    // Store port request from the controller.
    typedef struct packed {
        logic        we;
        logic [15:0] waddr;
        logic [63:0] wdata;
        logic        re;
        logic [15:0] raddr;
    } t_mem_req;

endpackage

// File: design/audio_jitter_reservoir_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_jitter_reservoir_unit
// Ring FIFO of stereo audio frames with prebuffering and ramp padding.
// ---------------------------------------------------------------------------
// A write takes one transfer and its acknowledge is presented on the next
// cycle; finish and clear give no result. A pull gives frames_per_pull
// results, capped at 64 and none for zero: a queued frame takes a read
// issue, a frame store read and an emit, a ramp frame two 39-step
// bit-serial divisions, a silent or zero frame only an emit, each plus any
// output stall. No input is taken while a pull runs or while a result waits
// in the output register. The frame store has no clearing pass: reads only
// touch written entries.
module audio_jitter_reservoir_unit #(
    parameter int CAPACITY = ajr_pkg::CAPACITY_DEF,
    parameter int FADE_LEN = ajr_pkg::FADE_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_sample_ch0,
    input  logic signed [31:0] i_sample_ch1,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic               o_accepted,
    output logic signed [31:0] o_out_ch0,
    output logic signed [31:0] o_out_ch1,
    output logic               o_silence,
    output logic               o_end_of_stream,
    output logic               o_underrun_flag,
    output logic               o_last_frame,
    output logic [10:0]        o_fill_level,
    output logic               o_backpressure,
    output logic               o_refill_request,
    output logic [31:0]        o_underrun_count
);
    logic [10:0] r_watermark;
    logic [6:0]  r_pull;
    logic [1:0]  r_channels;
    ajr_pkg::t_mem_req w_req;
    logic [63:0] w_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watermark <= ajr_pkg::WATERMARK_RST;
            r_pull      <= ajr_pkg::PULL_RST;
            r_channels  <= ajr_pkg::CHANNELS_RST;
        end else if (i_cfg_valid) begin
            unique case (ajr_pkg::t_reg'(i_cfg_index))
                ajr_pkg::REG_WATERMARK: r_watermark <= i_cfg_data[10:0];
                ajr_pkg::REG_PULL:      r_pull      <= i_cfg_data[6:0];
                ajr_pkg::REG_CHANNELS:  r_channels  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    ajr_store #(.CAPACITY(CAPACITY)) u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    ajr_ctrl #(.CAPACITY(CAPACITY), .FADE_LEN(FADE_LEN)) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_sample_ch0     (i_sample_ch0),
        .i_sample_ch1     (i_sample_ch1),
        .i_watermark      (r_watermark),
        .i_pull           (r_pull),
        .i_channels       (r_channels),
        .o_req            (w_req),
        .i_rdata          (w_rdata),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_accepted       (o_accepted),
        .o_out_ch0        (o_out_ch0),
        .o_out_ch1        (o_out_ch1),
        .o_silence        (o_silence),
        .o_end_of_stream  (o_end_of_stream),
        .o_underrun_flag  (o_underrun_flag),
        .o_last_frame     (o_last_frame),
        .o_fill_level     (o_fill_level),
        .o_backpressure   (o_backpressure),
        .o_refill_request (o_refill_request),
        .o_underrun_count (o_underrun_count)
    );
endmodule

// File: design/ajr_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ajr_store
// Frame store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ajr_store #(
    parameter int CAPACITY = ajr_pkg::CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  ajr_pkg::t_mem_req     i_req,
    output logic [63:0]           o_rdata
);
    localparam int AW = $clog2(CAPACITY);

    logic [63:0] r_mem [CAPACITY];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/ajr_fade.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ajr_fade
// Multicycle signed divider for ramp padding: q = x / d truncated to zero.
// Restoring, one quotient bit a cycle on the magnitude.
// ---------------------------------------------------------------------------
module ajr_fade (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [38:0] i_num,     // signed product
    input  logic [6:0]  i_den,     // 1..64
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [38:0] r_q;
    logic [6:0]  r_rem;
    logic [6:0]  r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic        r_done;

    logic [7:0]  n_trial;
    logic [38:0] n_mag;
    logic [38:0] n_res;

    always_comb begin
        n_mag   = i_num[38] ? (~i_num + 39'd1) : i_num;
        n_trial = {r_rem, r_q[38]} - {1'b0, r_den};
        n_res   = r_neg ? (~r_q + 39'd1) : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= n_mag;
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[38];
                r_cnt  <= 6'd38;
            end else if (r_busy) begin
                if (!n_trial[7]) begin
                    r_rem <= n_trial[6:0];
                    r_q   <= {r_q[37:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[5:0], r_q[38]};
                    r_q   <= {r_q[37:0], 1'b0};
                end
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = n_res[31:0];
endmodule

// File: design/ajr_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ajr_ctrl
// Command sequencer: pointers, mode, pull loop over the frame store, padding.
// ---------------------------------------------------------------------------
module ajr_ctrl #(
    parameter int CAPACITY = ajr_pkg::CAPACITY_DEF,
    parameter int FADE_LEN = ajr_pkg::FADE_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_sample_ch0,
    input  logic signed [31:0] i_sample_ch1,
    input  logic [10:0]        i_watermark,
    input  logic [6:0]         i_pull,
    input  logic [1:0]         i_channels,
    output ajr_pkg::t_mem_req  o_req,
    input  logic [63:0]        i_rdata,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic               o_accepted,
    output logic signed [31:0] o_out_ch0,
    output logic signed [31:0] o_out_ch1,
    output logic               o_silence,
    output logic               o_end_of_stream,
    output logic               o_underrun_flag,
    output logic               o_last_frame,
    output logic [10:0]        o_fill_level,
    output logic               o_backpressure,
    output logic               o_refill_request,
    output logic [31:0]        o_underrun_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = AW + 1;
    localparam int LW = 17;
    localparam logic [LW-1:0] CAP_L  = LW'(CAPACITY);
    localparam logic [LW-1:0] BP_L   = LW'(CAPACITY - CAPACITY / 10);
    localparam logic [LW-1:0] HALF_L = LW'(CAPACITY / 2);
    localparam logic [6:0]    FADE_L = 7'(FADE_LEN);
    localparam logic [6:0]    PULL_L = 7'(ajr_pkg::MAX_PULL);

    typedef enum logic [1:0] {
        M_PREBUF  = 2'd0,
        M_STREAM  = 2'd1,
        M_UNDER   = 2'd2,
        M_DRAINED = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DIV0, S_DIV1, S_EMIT
    } t_state;

    t_state r_state;
    t_mode  r_mode;
    logic [PW-1:0] r_rp, r_wp;
    logic          r_fin;
    logic [31:0]   r_held0, r_held1;
    logic [31:0]   r_under_cnt;

    // pull bookkeeping
    logic [6:0]  r_n, r_take, r_idx, r_fade;
    logic        r_c1;
    logic [31:0] r_from0, r_from1;
    logic        r_sil, r_eos, r_und, r_wake;
    logic        r_rd_pend;

    // output register
    logic        r_ov;
    logic        r_kind, r_acc, r_sil_o, r_eos_o, r_und_o, r_last, r_bp, r_wake_o;
    logic [31:0] r_o0, r_o1, r_cnt_o;
    logic [10:0] r_lvl_o;

    // divider
    logic        n_dstart;
    logic [38:0] n_dnum;
    logic        w_ddone;
    logic [31:0] w_dq;
    logic        r_dch;
    logic [31:0] r_dq0;

    logic [LW-1:0] n_lvl_raw, n_level;
    logic [6:0]    n_nsat;
    logic          n_c1;

    ajr_fade u_fade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_dstart),
        .i_num   (n_dnum),
        .i_den   (r_fade),
        .o_done  (w_ddone),
        .o_quot  (w_dq)
    );

    always_comb begin
        n_lvl_raw = LW'((r_wp - r_rp) & PW'(2 * CAPACITY - 1));
        n_level   = (n_lvl_raw > CAP_L) ? CAP_L : n_lvl_raw;
        n_nsat    = (i_pull > PULL_L) ? PULL_L : i_pull;
        n_c1      = i_channels[1];
    end

    wire w_out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !w_out_free;
    wire w_acc = i_valid && !o_stall;

    // level after the whole pull: current level minus frames not yet read
    logic [LW-1:0] n_lvl_final;
    always_comb begin
        if (r_idx < r_take) begin
            n_lvl_final = n_level - LW'(r_take - r_idx);
        end else begin
            n_lvl_final = n_level;
        end
    end

    // emit index frame value
    logic [6:0]  n_k;
    logic        n_ramp;
    always_comb begin
        n_ramp   = (r_idx >= r_take) && (r_idx - r_take < r_fade);
        n_k      = r_fade - (r_idx - r_take) - 7'd1;
        n_dnum   = '0;
        n_dstart = 1'b0;
        if (r_state == S_DIV0) begin
            n_dnum   = 39'($signed(r_from0) * $signed({1'b0, n_k}));
            n_dstart = 1'b1;
        end else if (r_state == S_DIV1 && w_ddone && !r_dch) begin
            n_dnum   = 39'($signed(r_from1) * $signed({1'b0, n_k}));
            n_dstart = 1'b1;
        end
        o_req.we    = w_acc && (i_cmd == ajr_pkg::CMD_WRITE) && !r_fin && (n_level < CAP_L);
        o_req.waddr = 16'(r_wp[AW-1:0]);
        o_req.wdata = {n_c1 ? i_sample_ch1 : 32'd0, i_sample_ch0};
        o_req.re    = (r_state == S_READ);
        o_req.raddr = 16'(r_rp[AW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_PREBUF;
            r_rp <= '0; r_wp <= '0; r_fin <= 1'b0;
            r_held0 <= '0; r_held1 <= '0; r_under_cnt <= '0;
            r_ov <= 1'b0; r_rd_pend <= 1'b0; r_dch <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_cmd)
                            ajr_pkg::CMD_FINISH: r_fin <= 1'b1;
                            ajr_pkg::CMD_CLEAR: begin
                                r_rp <= '0; r_wp <= '0; r_fin <= 1'b0;
                                r_mode <= M_PREBUF;
                                r_held0 <= '0; r_held1 <= '0; r_under_cnt <= '0;
                            end
                            ajr_pkg::CMD_WRITE: begin
                                r_ov <= 1'b1; r_kind <= 1'b0; r_acc <= o_req.we;
                                r_o0 <= '0; r_o1 <= '0; r_sil_o <= 1'b0;
                                r_eos_o <= 1'b0; r_und_o <= 1'b0; r_last <= 1'b1;
                                r_wake_o <= 1'b0; r_cnt_o <= r_under_cnt;
                                if (o_req.we) begin
                                    r_wp    <= r_wp + PW'(1);
                                    r_lvl_o <= 11'(n_level + LW'(1));
                                    r_bp    <= (n_level + LW'(1)) >= BP_L;
                                end else begin
                                    r_lvl_o <= 11'(n_level);
                                    r_bp    <= n_level >= BP_L;
                                end
                            end
                            default: begin
                                if (n_nsat != 7'd0 && LW'(n_nsat) <= CAP_L) begin
                                    logic [6:0] v_take;
                                    logic [LW-1:0] v_rem;
                                    v_take = (n_level < LW'(n_nsat)) ? 7'(n_level) : n_nsat;
                                    v_rem  = n_level - LW'(v_take);
                                    r_n <= n_nsat; r_c1 <= n_c1; r_idx <= '0;
                                    r_sil <= 1'b0; r_eos <= 1'b0; r_und <= 1'b0;
                                    r_wake <= 1'b0; r_take <= 7'd0;
                                    r_fade <= 7'd1;
                                    r_from0 <= r_held0;
                                    r_from1 <= n_c1 ? r_held1 : 32'd0;
                                    r_state <= S_EMIT;
                                    if (r_fin) begin
                                        r_take <= v_take;
                                        r_mode <= (n_level <= LW'(n_nsat)) ? M_DRAINED
                                                                            : M_STREAM;
                                        r_sil  <= v_take == 7'd0;
                                        r_eos  <= n_level <= LW'(n_nsat);
                                    end else if (r_mode == M_UNDER || r_mode == M_STREAM ||
                                                 (r_mode == M_PREBUF &&
                                                  n_level >= LW'(i_watermark) &&
                                                  n_level >= LW'(n_nsat)) ||
                                                 r_mode == M_DRAINED) begin
                                        if (r_mode == M_DRAINED) begin
                                            r_sil  <= 1'b1;
                                            r_wake <= n_level < HALF_L;
                                        end else begin
                                            r_take <= v_take;
                                            r_wake <= v_rem < HALF_L;
                                            if (v_take < n_nsat) begin
                                                logic [6:0] v_gap;
                                                v_gap = n_nsat - v_take;
                                                r_fade <= (v_gap < FADE_L) ? v_gap : FADE_L;
                                                r_mode <= M_UNDER;
                                                r_und  <= 1'b1;
                                                r_under_cnt <= r_under_cnt + 32'd1;
                                            end else begin
                                                r_mode <= M_STREAM;
                                            end
                                        end
                                    end else begin
                                        r_sil  <= 1'b1;
                                        r_wake <= n_level < HALF_L;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // one frame read; data arrives next cycle
                    r_state <= S_EMIT;
                end
                S_DIV0: begin
                    r_dch <= 1'b0;
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (w_ddone) begin
                        if (!r_dch) begin
                            r_dq0 <= w_dq;
                            r_dch <= 1'b1;
                        end else begin
                            r_dch <= 1'b0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: ;
            endcase

            // emit path: at most one result per visit
            if (r_state == S_EMIT && w_out_free) begin
                logic [31:0] v0, v1;
                logic        v_go;
                v_go = 1'b1;
                v0 = '0; v1 = '0;
                if (r_idx < r_take) begin
                    if (!r_rd_pend) begin
                        r_rd_pend <= 1'b1;
                        r_state   <= S_READ;
                        v_go = 1'b0;
                    end else begin
                        v0 = i_rdata[31:0];
                        v1 = r_c1 ? i_rdata[63:32] : 32'd0;
                        r_rd_pend <= 1'b0;
                        r_rp <= r_rp + PW'(1);
                        r_from0 <= v0; r_from1 <= v1;
                        if (r_idx == r_n - 7'd1) begin
                            r_held0 <= v0; r_held1 <= v1;
                        end
                    end
                end else if (r_und && n_ramp) begin
                    if (!r_rd_pend) begin
                        r_rd_pend <= 1'b1;
                        r_state   <= S_DIV0;
                        v_go = 1'b0;
                    end else begin
                        v0 = r_dq0; v1 = w_dq;
                        r_rd_pend <= 1'b0;
                    end
                end
                if (r_und && r_idx == r_n - 7'd1) begin
                    r_held0 <= '0; r_held1 <= '0;
                end
                if (v_go) begin
                    r_ov <= 1'b1; r_kind <= 1'b1; r_acc <= 1'b0;
                    r_o0 <= v0; r_o1 <= v1;
                    r_sil_o <= r_sil; r_eos_o <= r_eos; r_und_o <= r_und;
                    r_last <= (r_idx == r_n - 7'd1);
                    r_lvl_o <= 11'(n_lvl_final);
                    r_bp <= n_lvl_final >= BP_L;
                    r_wake_o <= r_wake & !r_fin;
                    r_cnt_o <= r_under_cnt;
                    r_idx <= r_idx + 7'd1;
                    if (r_idx == r_n - 7'd1) r_state <= S_IDLE;
                end
            end
        end
    end

    assign o_valid          = r_ov;
    assign o_kind           = r_kind;
    assign o_accepted       = r_acc;
    assign o_out_ch0        = r_o0;
    assign o_out_ch1        = r_o1;
    assign o_silence        = r_sil_o;
    assign o_end_of_stream  = r_eos_o;
    assign o_underrun_flag  = r_und_o;
    assign o_last_frame     = r_last;
    assign o_fill_level     = r_lvl_o;
    assign o_backpressure   = r_bp;
    assign o_refill_request = r_wake_o;
    assign o_underrun_count = r_cnt_o;
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for audio_jitter_reservoir_unit: a queue-fed driver
// pushes commands, a predictor computes expected frames and acks, a monitor
// compares every result field against them.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CAP = ajr_pkg::CAPACITY_DEF;
    localparam int FADE = ajr_pkg::FADE_LEN_DEF;
    localparam int BP_HIGH = CAP - CAP / 10;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] s0;
        logic [31:0] s1;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic        accepted;
        logic [31:0] ch0;
        logic [31:0] ch1;
        logic        silence;
        logic        eos;
        logic        under;
        logic        last;
        logic [10:0] level;
        logic        bp;
        logic        wake;
        logic [31:0] ucount;
    } t_result;

    typedef enum logic [1:0] {
        M_PREBUF  = 2'd0,
        M_STREAM  = 2'd1,
        M_UNDER   = 2'd2,
        M_DRAINED = 2'd3
    } t_mode;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        dut_stall;
    logic [1:0]  in_cmd = ajr_pkg::CMD_WRITE;
    logic [31:0] in_s0 = '0;
    logic [31:0] in_s1 = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = ajr_pkg::REG_WATERMARK;
    logic [31:0] cfg_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        o_kind, o_acc, o_sil, o_eos, o_und, o_last, o_bp, o_wake;
    logic signed [31:0] o_ch0, o_ch1;
    logic [10:0] o_level;
    logic [31:0] o_ucount;

    audio_jitter_reservoir_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(dut_stall),
        .i_cmd(in_cmd), .i_sample_ch0(in_s0), .i_sample_ch1(in_s1),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_kind(o_kind), .o_accepted(o_acc), .o_out_ch0(o_ch0), .o_out_ch1(o_ch1),
        .o_silence(o_sil), .o_end_of_stream(o_eos), .o_underrun_flag(o_und),
        .o_last_frame(o_last), .o_fill_level(o_level), .o_backpressure(o_bp),
        .o_refill_request(o_wake), .o_underrun_count(o_ucount)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // reservoir shadow state
    logic [31:0] store0 [CAP];
    logic [31:0] store1 [CAP];
    logic [10:0] rd_ptr, wr_ptr;
    logic        finished;
    t_mode       mode;
    logic [31:0] held0, held1, underruns;
    logic [10:0] watermark;
    logic [6:0]  pull_size;
    logic [1:0]  channels;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      send_idle_pct = 0, recv_stall_pct = 0;
    int      errors = 0, frames_seen = 0, acks_seen = 0, underruns_seen = 0;
    int      cycles = 0;

    function automatic int level_now();
        int lv;
        lv = int'((wr_ptr - rd_ptr) & 11'h7FF);
        return lv > CAP ? CAP : lv;
    endfunction

    function automatic logic [31:0] ramp(logic [31:0] from, int k, int f);
        longint p;
        p = longint'($signed(from)) * k;
        return 32'(p / f);   // SV division truncates toward zero
    endfunction

    task automatic clear_reservoir();
        rd_ptr = 0; wr_ptr = 0; finished = 0; mode = M_PREBUF;
        held0 = 0; held1 = 0; underruns = 0;
    endtask

    task automatic predict_reservoir(t_item it);
        t_result r;
        logic [31:0] f0 [64];
        logic [31:0] f1 [64];
        logic two, sil, eos, und, wake;
        int n, avail, take, lv, gap, fade;
        logic [31:0] from0, from1;
        two = channels >= 2;
        r = '0;
        case (it.cmd)
            ajr_pkg::CMD_FINISH: finished = 1;
            ajr_pkg::CMD_CLEAR: clear_reservoir();
            ajr_pkg::CMD_WRITE: begin
                if (!finished && level_now() < CAP) begin
                    store0[wr_ptr[9:0]] = it.s0;
                    store1[wr_ptr[9:0]] = two ? it.s1 : 32'd0;
                    wr_ptr = wr_ptr + 1;
                    r.accepted = 1;
                end
                lv = level_now();
                r.last = 1; r.level = lv; r.bp = lv >= BP_HIGH; r.ucount = underruns;
                expected_results.push_back(r);
            end
            default: begin
                n = pull_size;
                if (n != 0) begin
                    if (n > 64) n = 64;
                    avail = level_now();
                    take = 0; sil = 0; eos = 0; und = 0; wake = 0;
                    for (int i = 0; i < 64; i++) begin f0[i] = 0; f1[i] = 0; end
                    if (finished) begin
                        take = avail < n ? avail : n;
                        for (int i = 0; i < take; i++) begin
                            f0[i] = store0[10'(rd_ptr + i)];
                            f1[i] = two ? store1[10'(rd_ptr + i)] : 32'd0;
                        end
                        rd_ptr = rd_ptr + take;
                        mode = avail <= n ? M_DRAINED : M_STREAM;
                        sil = take == 0; eos = mode == M_DRAINED;
                    end else begin
                        if (mode == M_UNDER) mode = M_STREAM;
                        if (mode == M_PREBUF && avail >= watermark && avail >= n)
                            mode = M_STREAM;
                        if (mode == M_STREAM) begin
                            take = avail < n ? avail : n;
                            for (int i = 0; i < take; i++) begin
                                f0[i] = store0[10'(rd_ptr + i)];
                                f1[i] = two ? store1[10'(rd_ptr + i)] : 32'd0;
                            end
                            if (take < n) begin
                                gap = n - take;
                                if (take > 0) begin
                                    from0 = f0[take-1]; from1 = f1[take-1];
                                end else begin
                                    from0 = held0; from1 = two ? held1 : 32'd0;
                                end
                                fade = gap < FADE ? gap : FADE;
                                for (int i = 0; i < fade; i++) begin
                                    f0[take+i] = ramp(from0, fade - i - 1, fade);
                                    f1[take+i] = ramp(from1, fade - i - 1, fade);
                                end
                                held0 = 0; held1 = 0; mode = M_UNDER;
                                underruns = underruns + 1; und = 1;
                            end else begin
                                held0 = f0[n-1]; held1 = f1[n-1];
                            end
                            rd_ptr = rd_ptr + take;
                            avail -= take;
                        end else sil = 1;
                        wake = avail < CAP / 2;
                    end
                    lv = level_now();
                    for (int i = 0; i < n; i++) begin
                        r.kind = 1; r.ch0 = f0[i]; r.ch1 = f1[i];
                        r.silence = sil; r.eos = eos; r.under = und;
                        r.last = i + 1 == n; r.level = lv; r.bp = lv >= BP_HIGH;
                        r.wake = wake; r.ucount = underruns;
                        expected_results.push_back(r);
                    end
                end
            end
        endcase
    endtask

    // driver
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n) begin
            if (in_valid && !dut_stall) predict_reservoir({in_cmd, in_s0, in_s1});
            if (!in_valid || !dut_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_item it;
                    it = pending_items.pop_front();
                    in_valid <= 1'b1; in_cmd <= it.cmd; in_s0 <= it.s0; in_s1 <= it.s1;
                end else in_valid <= 1'b0;
            end
            out_stall <= $urandom_range(99) < recv_stall_pct;
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result, kind %0d", o_kind);
                errors++;
            end else begin
                t_result e;
                e = expected_results.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_kind); errors++; end
                if (o_acc !== e.accepted) begin
                    $error("accepted exp %0d got %0d", e.accepted, o_acc); errors++; end
                if (o_ch0 !== e.ch0) begin
                    $error("out_ch0 exp %0d got %0d", $signed(e.ch0), o_ch0); errors++; end
                if (o_ch1 !== e.ch1) begin
                    $error("out_ch1 exp %0d got %0d", $signed(e.ch1), o_ch1); errors++; end
                if (o_sil !== e.silence) begin
                    $error("silence exp %0d got %0d", e.silence, o_sil); errors++; end
                if (o_eos !== e.eos) begin
                    $error("end_of_stream exp %0d got %0d", e.eos, o_eos); errors++; end
                if (o_und !== e.under) begin
                    $error("underrun_flag exp %0d got %0d", e.under, o_und); errors++; end
                if (o_last !== e.last) begin
                    $error("last_frame exp %0d got %0d", e.last, o_last); errors++; end
                if (o_level !== e.level) begin
                    $error("fill_level exp %0d got %0d", e.level, o_level); errors++; end
                if (o_bp !== e.bp) begin
                    $error("backpressure exp %0d got %0d", e.bp, o_bp); errors++; end
                if (o_wake !== e.wake) begin
                    $error("refill_request exp %0d got %0d", e.wake, o_wake); errors++; end
                if (o_ucount !== e.ucount) begin
                    $error("underrun_count exp %0d got %0d", e.ucount, o_ucount); errors++; end
                if (e.kind) frames_seen++; else acks_seen++;
                if (e.under && e.last) underruns_seen++;
            end
        end
        if (cycles >= LIMIT) begin
            $display("audio_jitter_reservoir_unit: mismatch");
            $finish;
        end
    end

    task automatic add(logic [1:0] c, logic [31:0] a = $urandom(), logic [31:0] b = $urandom());
        pending_items.push_back({c, a, b});
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);   // leave time for ramp frames and their divisions
    endtask

    task automatic write_reg(ajr_pkg::t_reg idx, logic [31:0] val);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            ajr_pkg::REG_WATERMARK: watermark = val[10:0];
            ajr_pkg::REG_PULL: pull_size = val[6:0];
            default: channels = val[1:0];
        endcase
        @(posedge clk);
    endtask

    // mostly writes with some pulls; finish rarely, clear more rarely
    task automatic random_burst(int count);
        for (int i = 0; i < count; i++) begin
            int p;
            p = $urandom_range(99);
            if (p < 65) add(ajr_pkg::CMD_WRITE);
            else if (p < 93) add(ajr_pkg::CMD_PULL);
            else if (p < 97) add(ajr_pkg::CMD_FINISH);
            else add(ajr_pkg::CMD_CLEAR);
        end
    endtask

    initial begin
        watermark = ajr_pkg::WATERMARK_RST;
        pull_size = ajr_pkg::PULL_RST;
        channels = ajr_pkg::CHANNELS_RST;
        clear_reservoir();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: silence while prebuffering, extremes, underrun ramp, drain
        write_reg(ajr_pkg::REG_WATERMARK, 4);
        write_reg(ajr_pkg::REG_PULL, 3);
        write_reg(ajr_pkg::REG_CHANNELS, 2);
        add(ajr_pkg::CMD_PULL);
        add(ajr_pkg::CMD_WRITE, 32'h7FFFFFFF, 32'h80000000);
        add(ajr_pkg::CMD_WRITE, 32'h80000000, 32'h7FFFFFFF);
        add(ajr_pkg::CMD_WRITE, 32'hFFFFFFFF, 32'h00000000);
        add(ajr_pkg::CMD_WRITE, 32'h00000000, 32'hFFFFFFFF);
        add(ajr_pkg::CMD_WRITE, 32'hAAAAAAAA, 32'h55555555);
        add(ajr_pkg::CMD_PULL);
        add(ajr_pkg::CMD_PULL);          // short pull: ramp from last real frame
        add(ajr_pkg::CMD_PULL);          // resumes, nothing queued: ramp from zero
        add(ajr_pkg::CMD_WRITE, 32'h12345678, 32'h87654321);
        add(ajr_pkg::CMD_FINISH);
        add(ajr_pkg::CMD_WRITE);         // dropped after finish
        add(ajr_pkg::CMD_PULL);
        add(ajr_pkg::CMD_PULL);
        add(ajr_pkg::CMD_CLEAR);
        drain();

        // phase sweep: idling patterns and register settings incl. extremes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            case (ph)
                0: begin write_reg(ajr_pkg::REG_WATERMARK, 1);
                         write_reg(ajr_pkg::REG_PULL, 1);
                         write_reg(ajr_pkg::REG_CHANNELS, 1); end
                1: begin write_reg(ajr_pkg::REG_WATERMARK, 8);
                         write_reg(ajr_pkg::REG_PULL, 5);
                         write_reg(ajr_pkg::REG_CHANNELS, 2); end
                2: begin write_reg(ajr_pkg::REG_WATERMARK, 0);
                         write_reg(ajr_pkg::REG_PULL, 20);
                         write_reg(ajr_pkg::REG_CHANNELS, 3); end
                3: begin write_reg(ajr_pkg::REG_WATERMARK, 2047);
                         write_reg(ajr_pkg::REG_PULL, 127);
                         write_reg(ajr_pkg::REG_CHANNELS, 0); end
                4: begin write_reg(ajr_pkg::REG_WATERMARK, 1024);
                         write_reg(ajr_pkg::REG_PULL, 0);
                         write_reg(ajr_pkg::REG_CHANNELS, 2); end
                default: begin write_reg(ajr_pkg::REG_WATERMARK, 3);
                         write_reg(ajr_pkg::REG_PULL, 64);
                         write_reg(ajr_pkg::REG_CHANNELS, 2); end
            endcase
            random_burst(35);
            if (ph == 3) add(ajr_pkg::CMD_FINISH);
            drain();
        end

        $display("covered %0d pulled frames, %0d write acks, %0d underrun pulls",
                 frames_seen, acks_seen, underruns_seen);
        $display("swept watermark, pull size and channel count extremes under four idling mixes");
        if (errors == 0) $display("audio_jitter_reservoir_unit: match");
        else $display("audio_jitter_reservoir_unit: mismatch");
        $finish;
    end
endmodule
